// ===== sv/signed_integer_to_radix_text_macros.svh =====
// Assertion helpers shared by the RTL; all sample on clk and are muted in reset.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication.
`define SIRT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sirt: same-cycle check failed");

// Next-cycle implication.
`define SIRT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sirt: next-cycle check failed");

`endif

// ===== sv/sirt_pkg.sv =====
package sirt_pkg;

	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 5;
	localparam int SYM_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_BASE_DEF = 16;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_PLUS      = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_PRINT_END = 8'd127;

	// byte idx of the 16-symbol alphabet
	function automatic logic [CHAR_W-1:0] sym_at(input logic [2*SYM_W-1:0] syms,
	                                              input logic [3:0] idx);
		return syms[idx*CHAR_W +: CHAR_W];
	endfunction

endpackage

// ===== sv/sirt_channels.sv =====
interface sirt_value_if;
	logic                              valid;
	logic                              ready;
	logic signed [sirt_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sirt_text_if;
	logic                        valid;
	logic                        ready;
	logic [sirt_pkg::CHAR_W-1:0] text_char;
	logic                        final_char;

	modport source (output valid, output text_char, output final_char, input ready);
	modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

// ===== sv/signed_integer_to_radix_text.sv =====
// Signed 32-bit integer to text in a programmable radix. Program base_len (the radix, 2..MAX_BASE)
// and the symbol bytes (symbol 0 in the low byte of symbols_low) while the block is idle. Each
// value accepted on "operand" comes out on "text" as one transaction per character: '-' for a
// negative value, then the digits most significant first, with final_char set on the last one.
// An alphabet that is too short, too long, has a non-printable byte, a '+' or '-', or a repeated
// symbol makes the value produce no transaction at all. One value is handled at a time; operand
// is not ready until the last character has been loaded into the output register, or until a
// bad alphabet has sent the sequencer back to idle. Operation: the block first builds the powers
// of the radix with one multiply-compare per cycle, then extracts each digit with a single
// compare-subtract unit that resolves one quotient bit per cycle. operand is ready again in the
// cycle after the load of the last character. A value against a bad alphabet passes through the
// load and check states and returns to idle. Backpressure on text holds the block only while it
// has a character to load; a stall that overlaps digit calculation costs nothing.
`include "signed_integer_to_radix_text_macros.svh"

module signed_integer_to_radix_text #(
	parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sirt_pkg::SYM_W-1:0]      cfg_data,
	sirt_value_if.sink                      operand,
	sirt_text_if.source                     text
);

	// digit width follows the largest radix; BIT_W is the width of the quotient-bit index in a digit
	localparam int DIG_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
	localparam int BIT_W = (DIG_W > 1) ? $clog2(DIG_W) : 1;
	localparam int VW    = sirt_pkg::VALUE_W;
	localparam int TW    = VW + DIG_W;          // shifted power for the trial subtract
	localparam int PW    = VW + sirt_pkg::LEN_W; // power times radix
	localparam int NPOW  = VW;                  // radix^0 .. radix^31 at most
	localparam int KW    = $clog2(NPOW);
	localparam logic [sirt_pkg::LEN_W-1:0] LEN_MAX = sirt_pkg::LEN_W'(MAX_BASE);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_CHECK = 6'b000100,
		S_SIGN  = 6'b001000,
		S_POW   = 6'b010000,
		S_DIG   = 6'b100000
	} state_t;

	// S_DIG also covers the output wait; a separate one-hot code keeps it readable
	typedef enum logic [1:0] {
		P_CALC = 2'b01,
		P_OUT  = 2'b10
	} dig_phase_t;

	state_t                          state_q;
	dig_phase_t                      phase_q;

	// configuration
	logic [sirt_pkg::LEN_W-1:0]      base_len_q;
	logic [2*sirt_pkg::SYM_W-1:0]    syms_q;
	logic                            base_ok;
	logic                            base_ok_q;

	// datapath
	logic [VW-1:0]                   raw_q;
	logic                            neg_q;
	logic [VW-1:0]                   rem_q;
	logic [VW-1:0]                   pw_q [NPOW];
	logic [KW-1:0]                   k_q;
	logic [BIT_W-1:0]                b_q;
	logic [BIT_W-1:0]                topbit;
	logic [BIT_W-1:0]                topbit_q;
	logic [DIG_W-1:0]                dig_q;

	// output register
	logic                            ovalid_q;
	logic [sirt_pkg::CHAR_W-1:0]     ochar_q;
	logic                            ofinal_q;
	logic                            ospace;
	logic                            dig_out;
	logic                            oload;
	logic                            last_load;

	logic [VW-1:0]                   mag;
	logic [VW-1:0]                   pw_rd;
	logic [PW-1:0]                   pw_next;
	logic                            pw_fits;
	logic [TW-1:0]                   trial;
	logic [TW-1:0]                   rem_ext;
	logic                            take_bit;
	logic [sirt_pkg::LEN_W-1:0]      len_m1;
	logic [sirt_pkg::CHAR_W-1:0]     dig_char;

	// assertion terms
	logic                            dig_legal;
	logic                            out_printable;

	//--------------------------------------------------------------------------
	// Configuration registers; a write to an unused index is dropped.
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= '0;
			syms_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sirt_pkg::REG_BASE_LEN:     base_len_q <= cfg_data[sirt_pkg::LEN_W-1:0];
				sirt_pkg::REG_SYMBOLS_LOW:  syms_q[sirt_pkg::SYM_W-1:0] <= cfg_data;
				sirt_pkg::REG_SYMBOLS_HIGH: syms_q[2*sirt_pkg::SYM_W-1:sirt_pkg::SYM_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Alphabet check: all pairwise compares side by side, registered. The result is consumed
	// in the check state, which follows the load state, so it reflects the current alphabet.
	always_comb begin
		logic [sirt_pkg::CHAR_W-1:0] c;
		base_ok = (base_len_q >= sirt_pkg::LEN_W'(2)) && (base_len_q <= LEN_MAX);
		for (int i = 0; i < MAX_BASE; i++) begin
			c = sirt_pkg::sym_at(syms_q, 4'(i));
			if (sirt_pkg::LEN_W'(i) < base_len_q) begin
				if (c < sirt_pkg::CHAR_PRINT_LO || c >= sirt_pkg::CHAR_PRINT_END ||
				    c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS)
					base_ok = 1'b0;
				for (int j = i + 1; j < MAX_BASE; j++) begin
					if (sirt_pkg::LEN_W'(j) < base_len_q &&
					    sirt_pkg::sym_at(syms_q, 4'(j)) == c)
						base_ok = 1'b0;
				end
			end
		end
	end

	// Top quotient bit of a digit: position of the top set bit of radix-1.
	always_comb begin
		len_m1 = base_len_q - sirt_pkg::LEN_W'(1);
		topbit = '0;
		for (int i = 0; i < DIG_W; i++) begin
			if (len_m1[i])
				topbit = BIT_W'(i);
		end
	end

	//--------------------------------------------------------------------------
	// Shared arithmetic
	//--------------------------------------------------------------------------
	assign mag      = raw_q[VW-1] ? (VW'(0) - raw_q) : raw_q;
	assign pw_rd    = pw_q[k_q];

	// power build: next power of the radix, kept while it does not exceed the magnitude
	assign pw_next  = PW'(pw_rd) * PW'(base_len_q);
	assign pw_fits  = pw_next <= PW'(rem_q);

	// digit extraction: restoring step against power << bit
	assign trial    = TW'(pw_rd) << b_q;
	assign rem_ext  = TW'(rem_q);
	assign take_bit = rem_ext >= trial;

	assign dig_char = sirt_pkg::sym_at(syms_q, 4'(dig_q));
	assign ospace   = !ovalid_q || text.ready;

	// a character enters the output register: the sign or a finished digit
	assign dig_out   = (state_q == S_DIG) && (phase_q == P_OUT);
	assign oload     = ospace && ((state_q == S_SIGN) || dig_out);
	assign last_load = dig_out && ospace && (k_q == '0);

	assign operand.ready = (state_q == S_IDLE);
	assign text.valid      = ovalid_q;
	assign text.text_char  = ochar_q;
	assign text.final_char = ofinal_q;

	//--------------------------------------------------------------------------
	// Sequencer
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= P_CALC;
			base_ok_q <= 1'b0;
			ovalid_q  <= 1'b0;
			k_q       <= '0;
			b_q       <= '0;
		end else begin
			base_ok_q <= base_ok;
			if (oload)
				ovalid_q <= 1'b1;
			else if (text.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (operand.valid)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					k_q <= '0;
					if (!base_ok_q)
						state_q <= S_IDLE;
					else if (neg_q)
						state_q <= S_SIGN;
					else
						state_q <= S_POW;
				end
				S_SIGN: begin
					if (ospace)
						state_q <= S_POW;
				end
				S_POW: begin
					if (pw_fits) begin
						k_q <= k_q + KW'(1);
					end else begin
						b_q     <= topbit_q;
						phase_q <= P_CALC;
						state_q <= S_DIG;
					end
				end
				S_DIG: begin
					unique case (phase_q)
						P_CALC: begin
							if (b_q == '0)
								phase_q <= P_OUT;
							else
								b_q <= b_q - BIT_W'(1);
						end
						P_OUT: begin
							if (ospace) begin
								if (k_q == '0) begin
									state_q <= S_IDLE;
								end else begin
									k_q     <= k_q - KW'(1);
									b_q     <= topbit_q;
									phase_q <= P_CALC;
								end
							end
						end
						default: phase_q <= P_CALC;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && operand.valid)
			raw_q <= operand.value;
		if (state_q == S_LOAD) begin
			neg_q    <= raw_q[VW-1];
			rem_q    <= mag;
			topbit_q <= topbit;
		end
		if (state_q == S_CHECK)
			pw_q[0] <= VW'(1);
		if (state_q == S_SIGN && ospace) begin
			ochar_q  <= sirt_pkg::CHAR_MINUS;
			ofinal_q <= 1'b0;
		end
		if (state_q == S_POW) begin
			dig_q <= '0;
			if (pw_fits)
				pw_q[KW'(k_q + KW'(1))] <= pw_next[VW-1:0];
		end
		if (state_q == S_DIG) begin
			if (phase_q == P_CALC && take_bit) begin
				rem_q        <= rem_ext[VW-1:0] - trial[VW-1:0];
				dig_q[b_q]   <= 1'b1;
			end
			if (phase_q == P_OUT && ospace) begin
				ochar_q  <= dig_char;
				ofinal_q <= (k_q == '0);
				dig_q    <= '0;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Assertions
	//--------------------------------------------------------------------------
	assign dig_legal     = sirt_pkg::LEN_W'(dig_q) < base_len_q;
	assign out_printable = (ochar_q >= sirt_pkg::CHAR_PRINT_LO) &&
	                       (ochar_q < sirt_pkg::CHAR_PRINT_END);

	// a finished digit never reaches the radix
	`SIRT_ASSERT_NOW(a_digit_in_range, dig_out, dig_legal)
	// a non-final character pending means the value is still in progress
	`SIRT_ASSERT_NOW(a_busy_until_final, (ovalid_q && !ofinal_q), (!operand.ready))
	// only a valid alphabet emits, so every character is printable
	`SIRT_ASSERT_NOW(a_printable_out, text.valid, out_printable)
	// loading the last digit returns the sequencer to idle
	`SIRT_ASSERT_NEXT(a_final_to_idle, last_load, (state_q == S_IDLE && ofinal_q))

endmodule

// ===== dv/sirt_text_checker.sv =====
module sirt_text_checker
	import sirt_pkg::*;
#(
	parameter int MAX_BASE = MAX_BASE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SYM_W-1:0]     cfg_data,
	sirt_value_if                operand,
	sirt_text_if                 text,
	output int                   error_count,
	output int                   chars_outstanding
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_beat_t;

	// shadow copy of the config registers
	logic [LEN_W-1:0]   radix_reg;
	logic [2*SYM_W-1:0] alphabet;

	text_beat_t expected_text[$];
	int         bad;

	function automatic bit alphabet_ok();
		logic [CHAR_W-1:0] c;
		if (radix_reg < 2 || radix_reg > MAX_BASE || radix_reg > 16)
			return 1'b0;
		for (int i = 0; i < radix_reg; i++) begin
			c = alphabet[i*CHAR_W +: CHAR_W];
			if (c < CHAR_PRINT_LO || c >= CHAR_PRINT_END || c == CHAR_PLUS || c == CHAR_MINUS)
				return 1'b0;
			for (int j = i + 1; j < radix_reg; j++)
				if (alphabet[j*CHAR_W +: CHAR_W] == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queue up the characters one value turns into
	function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] rad;
		logic [3:0]         digits[$];
		text_beat_t         beat;
		if (!alphabet_ok())
			return;
		rad = VALUE_W'(radix_reg);
		mag = v[VALUE_W-1] ? (32'd0 - v) : v;
		do begin
			digits.push_front(4'(mag % rad));
			mag = mag / rad;
		end while (mag != 0);
		if (v[VALUE_W-1]) begin
			beat.ch   = CHAR_MINUS;
			beat.last = 1'b0;
			expected_text.push_back(beat);
		end
		while (digits.size() != 0) begin
			beat.ch   = alphabet[digits.pop_front()*CHAR_W +: CHAR_W];
			beat.last = (digits.size() == 0);
			expected_text.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_beat_t want;
		if (!arst_n) begin
			radix_reg = '0;
			alphabet  = '0;
			expected_text.delete();
			bad = 0;
			error_count       <= 0;
			chars_outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BASE_LEN:     radix_reg = cfg_data[LEN_W-1:0];
					REG_SYMBOLS_LOW:  alphabet[SYM_W-1:0] = cfg_data;
					REG_SYMBOLS_HIGH: alphabet[2*SYM_W-1:SYM_W] = cfg_data;
					default: ;
				endcase
			end
			if (operand.valid && operand.ready)
				predict_text(operand.value);
			if (text.valid && text.ready) begin
				if (expected_text.size() == 0) begin
					$error("text: unexpected transaction, char 0x%02h final %0b",
						text.text_char, text.final_char);
					bad++;
				end else begin
					want = expected_text.pop_front();
					if (text.text_char !== want.ch) begin
						$error("text_char: expected 0x%02h, got 0x%02h", want.ch, text.text_char);
						bad++;
					end
					if (text.final_char !== want.last) begin
						$error("final_char: expected %0b, got %0b", want.last, text.final_char);
						bad++;
					end
				end
			end
			error_count       <= bad;
			chars_outstanding <= expected_text.size();
		end
	end

endmodule

// ===== dv/tb_signed_integer_to_radix_text.sv =====
module tb_signed_integer_to_radix_text;
	import sirt_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 225;
	localparam int QUIET_TAIL    = 60;    // last values go with no idling at all
	localparam int SETTLE_CYCLES = 150;   // outlasts a negative radix-2 value, the slowest case
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RUN_LIMIT     = 800000;

	// ways to break an alphabet
	typedef enum int {
		BAD_TOO_SHORT,
		BAD_TOO_LONG,
		BAD_LOW_CHAR,
		BAD_HIGH_CHAR,
		BAD_PLUS,
		BAD_MINUS,
		BAD_REPEAT
	} base_fault_e;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SYM_W-1:0]     cfg_data;
	int                   error_count;
	int                   chars_outstanding;

	bit idle_on = 1'b1;
	int stall_left = 0;

	sirt_value_if operand_ch();
	sirt_text_if  text_ch();

	signed_integer_to_radix_text dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operand   (operand_ch),
		.text      (text_ch)
	);

	sirt_text_checker text_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.operand           (operand_ch),
		.text              (text_ch),
		.error_count       (error_count),
		.chars_outstanding (chars_outstanding)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Text sink: random backpressure bursts while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			text_ch.ready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			text_ch.ready <= 1'b0;
			stall_left    <= $urandom_range(0, 2);
		end else begin
			text_ch.ready <= 1'b1;
		end
	end

	// Symbol 0 goes to the lowest byte; bytes past the string are random junk
	// the block has to ignore.
	function automatic logic [2*SYM_W-1:0] alphabet_of(input string s);
		logic [2*SYM_W-1:0] a;
		for (int i = 0; i < 16; i++)
			a[i*CHAR_W +: CHAR_W] = (i < s.len()) ? s[i] : CHAR_W'($urandom_range(0, 255));
		return a;
	endfunction

	function automatic void spoil_alphabet(input base_fault_e fault,
	                                       inout logic [LEN_W-1:0] len,
	                                       inout logic [2*SYM_W-1:0] syms);
		int pos;
		int other;
		pos = $urandom_range(0, int'(len) - 1);
		case (fault)
			BAD_TOO_SHORT: len = LEN_W'($urandom_range(0, 1));
			BAD_TOO_LONG:  len = LEN_W'($urandom_range(17, 31));
			BAD_LOW_CHAR:  syms[pos*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(0, 31));
			BAD_HIGH_CHAR: syms[pos*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(127, 255));
			BAD_PLUS:      syms[pos*CHAR_W +: CHAR_W] = CHAR_PLUS;
			BAD_MINUS:     syms[pos*CHAR_W +: CHAR_W] = CHAR_MINUS;
			BAD_REPEAT: begin
				other = $urandom_range(0, int'(len) - 2);
				if (other >= pos)
					other++;
				syms[pos*CHAR_W +: CHAR_W] = syms[other*CHAR_W +: CHAR_W];
			end
			default: ;
		endcase
	endfunction

	// Mix of full-range values, small ones, extremes, and radix powers and
	// powers minus one (where the digit count steps).
	function automatic logic signed [VALUE_W-1:0] pick_value(input int radix);
		logic signed [VALUE_W-1:0] mag;
		longint unsigned           pw;
		case ($urandom_range(0, 5))
			0, 1, 2: return $urandom;
			3: mag = $urandom_range(0, 2 * radix);
			4: begin
				pw = 1;
				repeat ($urandom_range(1, 31))
					if (pw * radix <= 64'h8000_0000)
						pw = pw * radix;
				mag = VALUE_W'(pw - $urandom_range(0, 1));
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Three back-to-back writes; junk in the unused upper bits of base_len.
	task automatic program_alphabet(input logic [LEN_W-1:0] len, input logic [2*SYM_W-1:0] syms);
		logic [SYM_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_BASE_LEN;
		cfg_data  <= len_word;
		@(posedge clk);
		cfg_index <= REG_SYMBOLS_LOW;
		cfg_data  <= syms[SYM_W-1:0];
		@(posedge clk);
		cfg_index <= REG_SYMBOLS_HIGH;
		cfg_data  <= syms[2*SYM_W-1:SYM_W];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// valid stays up across back-to-back transactions; it only drops for a gap
	// or at the end of a phase, so it never gets two updates in one step.
	task automatic send_value(input logic signed [VALUE_W-1:0] v);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			operand_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		operand_ch.valid <= 1'b1;
		operand_ch.value <= v;
		do
			@(posedge clk);
		while (!operand_ch.ready);
	endtask

	// Wait for every predicted character, then give a value that makes no text
	// time to finish before the config changes.
	task automatic drain();
		int waited;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (chars_outstanding != 0 && waited < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [LEN_W-1:0] len, input logic [2*SYM_W-1:0] syms,
	                         input logic signed [VALUE_W-1:0] vals[$]);
		program_alphabet(len, syms);
		foreach (vals[i])
			send_value(vals[i]);
		operand_ch.valid <= 1'b0;
		drain();
	endtask

	initial begin
		#(RUN_LIMIT * 2 * CLK_HALF);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [LEN_W-1:0]          len;
		logic [2*SYM_W-1:0]        syms;
		logic signed [VALUE_W-1:0] vals[$];
		bit [255:0]                used;
		logic [CHAR_W-1:0]         c;
		bit                        spoiled;
		int                        n;
		int                        values_sent;

		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = REG_BASE_LEN;
		cfg_data         = '0;
		operand_ch.valid = 1'b0;
		operand_ch.value = '0;
		values_sent      = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset base_len is 0, so this value must produce nothing.
		send_value(32'sd7);
		operand_ch.valid <= 1'b0;
		drain();

		// --- directed ---
		// decimal: zero, sign boundaries, digit-count steps
		run_phase(5'd10, alphabet_of("0123456789"),
			'{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sh7FFF_FFFF,
			  32'sh8000_0000, 32'sd1000000000, -32'sd999999999});
		// radix 2: most negative value is the longest text, 33 characters
		run_phase(5'd2, alphabet_of("01"),
			'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1});
		// largest radix
		run_phase(5'd16, alphabet_of("0123456789ABCDEF"),
			'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'shDEAD_BEEF, 32'sd15, 32'sd16, -32'sd16});
		// bytes past base_len that would be illegal inside the alphabet are ignored
		syms = alphabet_of("xyz-+x");
		syms[7*CHAR_W +: CHAR_W] = 8'h00;
		run_phase(5'd3, syms, '{32'sd5, -32'sd5});
		// every kind of broken alphabet: no text at all
		for (int f = BAD_TOO_SHORT; f <= BAD_REPEAT; f++) begin
			len  = 5'd10;
			syms = alphabet_of("0123456789");
			spoil_alphabet(base_fault_e'(f), len, syms);
			run_phase(len, syms, '{32'sh8000_0000, pick_value(10)});
		end

		// --- random ---
		// Each phase: a fresh alphabet of distinct printable symbols with random junk past
		// its end; outside the quiet tail, one phase in six is broken on purpose.
		while (values_sent < RANDOM_ITEMS) begin
			idle_on = (values_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0:       len = 5'd2;
				1:       len = 5'd16;
				default: len = LEN_W'($urandom_range(2, 16));
			endcase
			used = '0;
			for (int i = 0; i < 16; i++) begin
				if (i < len) begin
					do
						c = CHAR_W'($urandom_range(32, 126));
					while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
					used[c] = 1'b1;
					syms[i*CHAR_W +: CHAR_W] = c;
				end else begin
					syms[i*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
				end
			end
			spoiled = (values_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 5) == 0);
			if (spoiled)
				spoil_alphabet(base_fault_e'($urandom_range(BAD_TOO_SHORT, BAD_REPEAT)), len, syms);
			n = spoiled ? 3 : $urandom_range(8, 30);
			vals.delete();
			repeat (n)
				vals.push_back(pick_value(spoiled ? 10 : int'(len)));
			run_phase(len, syms, vals);
			if (!spoiled)
				values_sent += n;
		end

		// Anything still predicted at this point never showed up.
		if (chars_outstanding != 0)
			$error("%0d expected characters never arrived", chars_outstanding);
		if (error_count == 0 && chars_outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sirt_pkg.sv
sv/sirt_channels.sv
sv/signed_integer_to_radix_text.sv
dv/sirt_text_checker.sv
dv/tb_signed_integer_to_radix_text.sv
